>>> rtl/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg: shared types and constants of the decelerating setpoint ramp
// Register indexes, reset values, fixed-point constants, the adder and
// iteration sizes and the configuration bundle passed from the register file to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SPEED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ZONE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATIO      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 2'd3;

  // Reset values
  localparam logic [15:0] RST_STEP_SPEED     = 16'd2048;
  localparam logic [15:0] RST_SLOW_ZONE      = 16'd1000;
  localparam logic [16:0] RST_MIN_RATIO      = 17'd65536;
  localparam logic [15:0] RST_POSITION_LIMIT = 16'd30200;

  // Q0.16 ratio constants
  localparam logic [16:0] RATIO_ONE     = 17'd65536;
  localparam logic [16:0] RATIO_DEFAULT = 17'd3277;

  // Shared adder and iteration count
  localparam int unsigned ALU_W  = 34;
  localparam int unsigned NSTEPS = 16;
  localparam int unsigned CNT_W  = $clog2(NSTEPS);

  typedef struct packed {
    logic [15:0] step_speed;
    logic [15:0] slow_zone;
    logic [16:0] min_ratio;
    logic [15:0] position_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/drp_alu.sv
// ----------------------------------------------------------------------------
// drp_alu: shared add/subtract unit
// One wide adder with carry out, used for 1 - r, the divide trial subtract,
// the shift-add multiply steps and the factor sum.
// ----------------------------------------------------------------------------
`default_nettype none

module drp_alu (
  input  wire logic [drp_pkg::ALU_W-1:0] a_i,
  input  wire logic [drp_pkg::ALU_W-1:0] b_i,
  input  wire logic                      sub_i,
  output      logic [drp_pkg::ALU_W-1:0] sum_o,
  output      logic                      carry_o
);

  logic [drp_pkg::ALU_W-1:0] b_x;

  // Subtract as a + ~b + 1; carry out set means no borrow (a >= b).
  assign b_x = b_i ^ {drp_pkg::ALU_W{sub_i}};
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_x}
                          + {{drp_pkg::ALU_W{1'b0}}, sub_i};

endmodule

`default_nettype wire

>>> rtl/drp_cfg.sv
// ----------------------------------------------------------------------------
// drp_cfg: configuration register file
// Holds the four ramp registers and derives the effective min ratio
// (zero maps to the default, values above one saturate).
// ----------------------------------------------------------------------------
`default_nettype none

module drp_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [drp_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  wire logic [drp_pkg::CFG_DATA_W-1:0] wr_data_i,
  output      drp_pkg::cfg_t                  cfg_o,
  output      logic [16:0]                    ratio_o
);

  drp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_speed     <= drp_pkg::RST_STEP_SPEED;
      cfg_q.slow_zone      <= drp_pkg::RST_SLOW_ZONE;
      cfg_q.min_ratio      <= drp_pkg::RST_MIN_RATIO;
      cfg_q.position_limit <= drp_pkg::RST_POSITION_LIMIT;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        drp_pkg::CFG_STEP_SPEED:     cfg_q.step_speed     <= wr_data_i[15:0];
        drp_pkg::CFG_SLOW_ZONE:      cfg_q.slow_zone      <= wr_data_i[15:0];
        drp_pkg::CFG_MIN_RATIO:      cfg_q.min_ratio      <= wr_data_i;
        drp_pkg::CFG_POSITION_LIMIT: cfg_q.position_limit <= wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_q.min_ratio == 17'd0) begin
      ratio_o = drp_pkg::RATIO_DEFAULT;
    end else if (cfg_q.min_ratio > drp_pkg::RATIO_ONE) begin
      ratio_o = drp_pkg::RATIO_ONE;
    end else begin
      ratio_o = cfg_q.min_ratio;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/decelerating_setpoint_ramp.sv
// ----------------------------------------------------------------------------
// decelerating_setpoint_ramp: slew-rate limited setpoint with a slow zone
// Each accepted target_pos moves the stored position toward it by one step
// and returns the new position plus an at_target flag. Far from the target
// the step is step_speed (unsigned Q8.8); within slow_zone it shrinks to
// step_speed * (r + (1 - r) * d / zone), rounded up and never below 1, and
// the move snaps to the target once the remaining distance fits in the step.
// The result is clamped to position_limit and becomes the stored position.
// The block works on one item at a time. The divide and multiply steps
// run through one shared 34-bit adder under a small sequencer: a 16-step
// restoring divide for d / zone, a 16-step shift-add multiply for
// (1 - r) * q, one add for the factor, and a 16-step shift-add multiply by
// the speed. An item outside the slow zone (or with the zone at zero) skips
// the divide and the first multiply, an item already at the stored position
// skips all of them, and a result that is still stalled in the output
// register holds the next one in the finish step. in_stall_o is high while
// an item is in work; a finished result waits in the output register and a
// new target may be taken meanwhile. Configuration writes are always accepted
// (cfg_ready_o is tied high) and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module decelerating_setpoint_ramp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // target channel
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [15:0]                    target_pos_i,
  // result channel
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [15:0]                    position_o,
  output      logic                           at_target_o,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [drp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_MUL1,
    ST_ADDF,
    ST_MUL2,
    ST_FINISH
  } state_e;

  localparam logic [drp_pkg::CNT_W-1:0] CNT_LAST = drp_pkg::CNT_W'(drp_pkg::NSTEPS - 1);

  state_e state_q;

  // Configuration
  drp_pkg::cfg_t cfg;
  logic [16:0]   ratio;

  assign cfg_ready_o = 1'b1;

  drp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .ratio_o    (ratio)
  );

  // Datapath registers
  logic [15:0]                 cur_q;      // stored position
  logic [15:0]                 target_q;
  logic [15:0]                 dist_q;
  logic                        move_q;     // distance nonzero
  logic [15:0]                 rem_q;      // divide remainder
  logic [drp_pkg::ALU_W-1:0]   acc_q;      // multiply high word
  logic [15:0]                 lo_q;       // quotient, then multiplier bits
  logic [32:0]                 mcand_q;    // 1 - r, then the factor F
  logic [drp_pkg::CNT_W-1:0]   cnt_q;
  logic                        out_valid_q;
  logic [15:0]                 position_q;
  logic                        at_target_q;

  // Shared adder
  logic [drp_pkg::ALU_W-1:0] alu_a;
  logic [drp_pkg::ALU_W-1:0] alu_b;
  logic                      alu_sub;
  logic [drp_pkg::ALU_W-1:0] alu_sum;
  logic                      alu_carry;

  drp_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_SETUP: begin
        // 1 - r in Q0.16
        alu_a   = drp_pkg::ALU_W'(drp_pkg::RATIO_ONE);
        alu_b   = drp_pkg::ALU_W'(ratio);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        // trial subtract of the zone from the doubled remainder
        alu_a   = drp_pkg::ALU_W'({rem_q, 1'b0});
        alu_b   = drp_pkg::ALU_W'(cfg.slow_zone);
        alu_sub = 1'b1;
      end
      ST_MUL1, ST_MUL2: begin
        alu_a = acc_q;
        alu_b = lo_q[0] ? drp_pkg::ALU_W'(mcand_q) : '0;
      end
      ST_ADDF: begin
        // F = r * 2^16 + (1 - r) * q
        alu_a = drp_pkg::ALU_W'({ratio, 16'd0});
        alu_b = drp_pkg::ALU_W'({acc_q[15:0], lo_q});
      end
      default: ;
    endcase
  end

  // Distance at setup
  logic        tgt_ge_cur;
  logic [15:0] distance;

  assign tgt_ge_cur = (target_q >= cur_q);
  assign distance   = tgt_ge_cur ? (target_q - cur_q) : (cur_q - target_q);

  // Step: ceil(speed * F / 2^40), at least 1. Product is {acc_q, lo_q}.
  logic [9:0]  step_raw;
  logic [9:0]  step;
  logic [15:0] new_pos;
  logic [15:0] clamped;

  assign step_raw = {1'b0, acc_q[32:24]} + 10'(|{acc_q[23:0], lo_q});
  assign step     = (step_raw == 10'd0) ? 10'd1 : step_raw;

  always_comb begin
    priority if (!move_q) begin
      new_pos = cur_q;
    end else if (dist_q <= {6'd0, step}) begin
      new_pos = target_q;
    end else if (cur_q < target_q) begin
      new_pos = cur_q + {6'd0, step};
    end else begin
      new_pos = cur_q - {6'd0, step};
    end
  end

  assign clamped = (new_pos > cfg.position_limit) ? cfg.position_limit : new_pos;

  logic out_free;
  assign out_free = !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      target_q    <= '0;
      dist_q      <= '0;
      move_q      <= 1'b0;
      rem_q       <= '0;
      acc_q       <= '0;
      lo_q        <= '0;
      mcand_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      position_q  <= '0;
      at_target_q <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            target_q <= target_pos_i;
            state_q  <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          dist_q  <= distance;
          move_q  <= (distance != 16'd0);
          rem_q   <= distance;
          cnt_q   <= '0;
          acc_q   <= '0;
          priority if (distance == 16'd0) begin
            state_q <= ST_FINISH;
          end else if (cfg.slow_zone == 16'd0 || distance >= cfg.slow_zone) begin
            // full speed: F is exactly 1.0 in Q0.32
            mcand_q <= 33'h1_0000_0000;
            lo_q    <= cfg.step_speed;
            state_q <= ST_MUL2;
          end else begin
            mcand_q <= alu_sum[32:0];
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          lo_q  <= {lo_q[14:0], alu_carry};
          rem_q <= alu_carry ? alu_sum[15:0] : {rem_q[14:0], 1'b0};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            acc_q   <= '0;
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          acc_q <= {alu_carry, alu_sum[drp_pkg::ALU_W-1:1]};
          lo_q  <= {alu_sum[0], lo_q[15:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_ADDF;
          end
        end
        ST_ADDF: begin
          mcand_q <= alu_sum[32:0];
          acc_q   <= '0;
          lo_q    <= cfg.step_speed;
          cnt_q   <= '0;
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_q <= {alu_carry, alu_sum[drp_pkg::ALU_W-1:1]};
          lo_q  <= {alu_sum[0], lo_q[15:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for the output register to free up
          if (out_free) begin
            cur_q       <= clamped;
            position_q  <= clamped;
            at_target_q <= (clamped == target_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign position_o  = position_q;
  assign at_target_o = at_target_q;

`ifndef SYNTHESIS
  // A finished item lands in the output register and in the stored position.
  a_finish_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=>
      (out_valid_o && cur_q == position_o && state_q == ST_IDLE))
    else $error("finished item did not reach output");

  // The last divide step hands over to the first multiply.
  a_div_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CNT_LAST) |=> (state_q == ST_MUL1 && acc_q == '0))
    else $error("divide did not hand over to multiply");

  // A delivered position respects the clamp.
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (position_o <= cfg.position_limit))
    else $error("position above limit");

  // The stored position only changes when a result is produced.
  a_cur_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FINISH) |=> $stable(cur_q))
    else $error("stored position changed mid-item");
`endif

endmodule

`default_nettype wire

>>> bench/decelerating_setpoint_ramp_test.sv
// ----------------------------------------------------------------------------
// decelerating_setpoint_ramp_test: self-checking bench for the setpoint ramp
// Drives target transfers and register writes into the ramp, predicts every
// result with a cycle-free model of the step law, and compares each result
// transfer field by field. A directed table covers the corner settings,
// then random phases change the registers while idle and chase random
// destinations so that the slow zone, the snap and the clamp are all hit.
// ----------------------------------------------------------------------------
`default_nettype none

module decelerating_setpoint_ramp_test;

  localparam int unsigned RANDOM_TARGETS = 1850;
  localparam int unsigned STALL_LIMIT    = 4000;  // cycles without any transfer
  localparam int unsigned TAIL_CYCLES    = 64;    // longer than one slow-zone item

  typedef struct packed {
    logic [15:0] position;
    logic        at_target;
  } ramp_result_t;

  typedef enum logic {ROW_WRITE, ROW_TARGET} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [drp_pkg::CFG_IDX_W-1:0] index;
    logic [16:0]                   value;      // register data or target position
    logic                          typed;      // expectation given in the row
    ramp_result_t                  expected;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [15:0]                    target_pos_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [15:0]                    position_o;
  logic                           at_target_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [drp_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [drp_pkg::CFG_DATA_W-1:0] cfg_data_i;

  decelerating_setpoint_ramp uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .target_pos_i (target_pos_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o),
    .at_target_o  (at_target_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 8-unit period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Shadow of the block: register copies and the stored position
  logic [15:0]  reg_speed;
  logic [15:0]  reg_zone;
  logic [16:0]  reg_ratio;
  logic [15:0]  reg_limit;
  logic [15:0]  ramp_pos;

  ramp_result_t pending_positions[$];
  plan_row_t    directed_plan[$];
  int unsigned  mismatch_count;
  int unsigned  quiet_cycles;
  int unsigned  target_count;
  bit           idling_enabled;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // One tick of the step law. Updates the shadow position.
  function automatic ramp_result_t advance_position(input logic [15:0] target);
    logic [63:0]  distance;
    logic [63:0]  ratio;
    logic [63:0]  quot;
    logic [63:0]  factor;
    logic [63:0]  step;
    logic [63:0]  pos;
    ramp_result_t res;
    pos      = {48'd0, ramp_pos};
    distance = (target > ramp_pos) ? {48'd0, target - ramp_pos}
                                   : {48'd0, ramp_pos - target};
    if (distance != 0) begin
      // zero ratio falls back to 0.05, anything above one saturates
      ratio = (reg_ratio == 17'd0) ? {47'd0, drp_pkg::RATIO_DEFAULT} : {47'd0, reg_ratio};
      if (ratio > drp_pkg::RATIO_ONE) ratio = {47'd0, drp_pkg::RATIO_ONE};
      quot = {47'd0, drp_pkg::RATIO_ONE};
      if (reg_zone != 16'd0 && distance < reg_zone) quot = (distance << 16) / reg_zone;
      factor = (ratio << 16) + ({47'd0, drp_pkg::RATIO_ONE} - ratio) * quot;
      // Q8.8 speed times Q0.32 factor, rounded up to whole units
      step = ({48'd0, reg_speed} * factor + 64'hFF_FFFF_FFFF) >> 40;
      if (step == 0) step = 64'd1;
      if (distance <= step) pos = {48'd0, target};
      else if (ramp_pos < target) pos = pos + step;
      else pos = pos - step;
    end
    if (pos > reg_limit) pos = {48'd0, reg_limit};
    ramp_pos      = pos[15:0];
    res.position  = ramp_pos;
    res.at_target = (ramp_pos == target);
    return res;
  endfunction

  function automatic void plan_write(input logic [drp_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [16:0] data);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.value = data;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_target(input logic [15:0] target, input logic typed,
                                      input logic [15:0] pos, input logic at);
    plan_row_t row;
    row                    = '0;
    row.kind               = ROW_TARGET;
    row.value              = {1'b0, target};
    row.typed              = typed;
    row.expected.position  = pos;
    row.expected.at_target = at;
    directed_plan.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_target(input logic [15:0] target, input logic typed,
                             input ramp_result_t typed_result);
    int unsigned  gap;
    ramp_result_t predicted;
    gap = 0;
    if (idling_enabled && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    target_pos_i <= target;
    do @(posedge clk_i); while (in_stall_o);
    predicted = advance_position(target);
    pending_positions.push_back(typed ? typed_result : predicted);
    target_count++;
    @(negedge clk_i);
  endtask

  // Drop the target valid and wait for all results to drain.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [drp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      drp_pkg::CFG_STEP_SPEED:     reg_speed = data[15:0];
      drp_pkg::CFG_SLOW_ZONE:      reg_zone  = data[15:0];
      drp_pkg::CFG_MIN_RATIO:      reg_ratio = data;
      drp_pkg::CFG_POSITION_LIMIT: reg_limit = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random register value, biased toward the extremes. The 16-bit
  // registers get junk in the top data bit, which must be dropped.
  function automatic logic [16:0] pick_setting(input logic [drp_pkg::CFG_IDX_W-1:0] idx);
    int unsigned pick;
    logic        junk;
    pick = $urandom_range(0, 9);
    junk = $urandom_range(0, 1);
    case (idx)
      drp_pkg::CFG_STEP_SPEED:
        case (pick)
          0: return {junk, 16'd0};
          1: return {junk, 16'd1};
          2: return {junk, 16'hFFFF};
          3, 4, 5: return {junk, 16'($urandom_range(256, 4096))};
          default: return {junk, 16'($urandom)};
        endcase
      drp_pkg::CFG_SLOW_ZONE:
        case (pick)
          0: return {junk, 16'd0};
          1: return {junk, 16'd1};
          2: return {junk, 16'hFFFF};
          3, 4, 5, 6: return {junk, 16'($urandom_range(2, 4000))};
          default: return {junk, 16'($urandom)};
        endcase
      drp_pkg::CFG_MIN_RATIO:
        case (pick)
          0: return 17'd0;
          1: return 17'd1;
          2: return drp_pkg::RATIO_ONE;
          3: return 17'h1FFFF;
          4: return 17'($urandom_range(65537, 131071));
          default: return 17'($urandom_range(0, 65536));
        endcase
      default:
        case (pick)
          0: return {junk, 16'd0};
          1: return {junk, 16'hFFFF};
          2: return {junk, drp_pkg::RST_POSITION_LIMIT};
          default: return {junk, 16'($urandom)};
        endcase
    endcase
  endfunction

  // Result checker: oldest expectation first
  always @(posedge clk_i) begin
    ramp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_positions.size() == 0) begin
        flag_mismatch($sformatf("unexpected result position=%0d at_target=%0b",
                                position_o, at_target_o));
      end else begin
        want = pending_positions.pop_front();
        if (position_o !== want.position)
          flag_mismatch($sformatf("position %0d, expected %0d", position_o, want.position));
        if (at_target_o !== want.at_target)
          flag_mismatch($sformatf("at_target %0b, expected %0b (position %0d)",
                                  at_target_o, want.at_target, want.position));
      end
    end
  end

  // Watchdog: any transfer on any channel rearms it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result-side back-pressure: bursts of stall and of flow
  initial begin
    int unsigned burst;
    logic        level;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = $urandom_range(1, 18);
      level = idling_enabled && ($urandom_range(0, 2) == 0);
      repeat (burst) begin
        @(negedge clk_i);
        out_stall_i <= level;
      end
    end
  end

  initial begin
    plan_row_t    row;
    ramp_result_t typed_result;
    int unsigned  phase_targets;
    int unsigned  phase_len;
    int unsigned  kind;
    int unsigned  hold;
    int unsigned  span;
    int           dest;
    logic [15:0]  target;

    in_valid_i     = 1'b0;
    target_pos_i   = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    mismatch_count = 0;
    target_count   = 0;
    idling_enabled = 1'b1;
    rst_ni         = 1'b0;

    reg_speed = drp_pkg::RST_STEP_SPEED;
    reg_zone  = drp_pkg::RST_SLOW_ZONE;
    reg_ratio = drp_pkg::RST_MIN_RATIO;
    reg_limit = drp_pkg::RST_POSITION_LIMIT;
    ramp_pos  = '0;

    // Directed table. Reset speed is 8.0 per tick; with the ratio at one
    // every step is the full speed.
    plan_target(16'd0,     1'b1, 16'd0,  1'b1);   // already at target after reset
    plan_target(16'hFFFF,  1'b1, 16'd8,  1'b0);   // full speed from reset
    plan_target(16'hFFFF,  1'b1, 16'd16, 1'b0);
    plan_write(drp_pkg::CFG_STEP_SPEED, 17'd0);     // zero speed: minimum step of one
    plan_target(16'hFFFF,  1'b1, 16'd17, 1'b0);
    plan_write(drp_pkg::CFG_POSITION_LIMIT, 17'd0); // limit below position
    plan_target(16'hFFFF,  1'b1, 16'd0,  1'b0);
    plan_target(16'd0,     1'b1, 16'd0,  1'b1);
    plan_write(drp_pkg::CFG_POSITION_LIMIT, 17'hFFFF);
    plan_write(drp_pkg::CFG_STEP_SPEED, 17'hFFFF);  // fastest: 256 per tick
    plan_target(16'hFFFF,  1'b1, 16'd256, 1'b0);
    plan_write(drp_pkg::CFG_SLOW_ZONE, 17'd0);      // zero zone: never slows
    plan_target(16'd1000,  1'b1, 16'd512, 1'b0);
    plan_write(drp_pkg::CFG_STEP_SPEED, 17'h10800); // top data bit dropped: 8.0
    plan_target(16'd0,     1'b0, '0, 1'b0);
    plan_write(drp_pkg::CFG_SLOW_ZONE, 17'hFFFF);
    plan_write(drp_pkg::CFG_MIN_RATIO, 17'd0);      // zero ratio -> 0.05
    plan_target(16'd0,     1'b0, '0, 1'b0);
    plan_target(16'd300,   1'b0, '0, 1'b0);
    plan_write(drp_pkg::CFG_MIN_RATIO, 17'h1FFFF);  // ratio above one saturates
    plan_target(16'd0,     1'b0, '0, 1'b0);
    plan_write(drp_pkg::CFG_MIN_RATIO, 17'd1);
    plan_target(16'hFFFF,  1'b0, '0, 1'b0);
    plan_write(drp_pkg::CFG_SLOW_ZONE, 17'd1);
    plan_target(16'd40000, 1'b0, '0, 1'b0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        write_reg(row.index, row.value);
      end else begin
        send_target(row.value[15:0], row.typed, row.expected);
      end
    end

    // Random phases: new settings while idle, then chase destinations
    target_count = 0;
    while (target_count < RANDOM_TARGETS) begin
      wait_idle();
      if (target_count >= RANDOM_TARGETS * 85 / 100) idling_enabled = 1'b0;
      if ($urandom_range(0, 1))
        write_reg(drp_pkg::CFG_STEP_SPEED, pick_setting(drp_pkg::CFG_STEP_SPEED));
      if ($urandom_range(0, 1))
        write_reg(drp_pkg::CFG_SLOW_ZONE, pick_setting(drp_pkg::CFG_SLOW_ZONE));
      if ($urandom_range(0, 1))
        write_reg(drp_pkg::CFG_MIN_RATIO, pick_setting(drp_pkg::CFG_MIN_RATIO));
      if ($urandom_range(0, 2) == 0)
        write_reg(drp_pkg::CFG_POSITION_LIMIT, pick_setting(drp_pkg::CFG_POSITION_LIMIT));
      phase_len     = $urandom_range(40, 160);
      phase_targets = 0;
      while (phase_targets < phase_len) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          // a nearby destination held for a while: slow zone and snap
          span = 2 * reg_zone + 4 * (reg_speed >> 8) + 8;
          dest = int'(ramp_pos) + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, span));
          if (dest < 0) dest = 0;
          if (dest > 65535) dest = 65535;
          target = 16'(dest);
          hold   = $urandom_range(1, 40);
        end else if (kind < 72) begin
          target = ramp_pos;
          hold   = $urandom_range(1, 3);
        end else if (kind < 90) begin
          target = 16'($urandom);
          hold   = 1;
        end else begin
          case ($urandom_range(0, 3))
            0:       target = 16'd0;
            1:       target = 16'hFFFF;
            2:       target = reg_limit;
            default: target = reg_limit + 16'd1;
          endcase
          hold = $urandom_range(1, 4);
        end
        repeat (hold) send_target(target, 1'b0, '0);
        phase_targets += hold;
      end
    end

    in_valid_i <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && pending_positions.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
